>>> rtl/core/flook_disk_request_scheduler_macros.svh
// assertion macros for the disk request scheduler
`ifndef FLOOK_DISK_REQUEST_SCHEDULER_MACROS_SVH
`define FLOOK_DISK_REQUEST_SCHEDULER_MACROS_SVH
// implication checked on every clock edge outside reset
`define FDRS_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define FDRS_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

>>> rtl/core/fdrs_pkg.sv
// shared types and constants for the disk request scheduler
package fdrs_pkg;
  localparam int QDepth = 32;
  localparam int SecBits = 20;
  localparam int IdxW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);
  localparam int EntW = SecBits + 8;
  localparam int TrkW = 20;
  localparam int SptW = 13;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_REM = 2'd1;
  localparam logic [1:0] CMD_NEXT = 2'd2;
  localparam logic [1:0] CMD_NOP = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_DISP = 3'd3;
  localparam logic [2:0] ST_IDLE = 3'd4;

  typedef struct packed {
    logic [1:0] command;
    logic [SecBits-1:0] sector;
    logic [7:0] tag;
  } fdrs_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [19:0] out_sector;
    logic [7:0] out_tag;
    logic [19:0] out_track;
    logic moving_outward;
    logic serving_first_queue;
  } fdrs_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_INS_RD, S_INS_WAIT, S_INS_CHK, S_REM_RD, S_REM_WAIT,
    S_REM_STEP, S_SCAN_RD, S_SCAN_WAIT, S_DIV, S_SCAN_CHK, S_DONE
  } fdrs_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture input transaction
    logic ins_init;    // start insert at tail
    logic ins_rd;      // read q[pos-1]
    logic ins_shift;   // q[pos]=q[pos-1], pos--
    logic ins_place;   // q[pos]=e, count++
    logic rem_init;    // start remove on first queue
    logic rem_rd;
    logic rem_step;    // process entry i
    logic rem_next_q;  // move to second queue
    logic scan_init;   // pick queue, start scan
    logic scan_rd;
    logic div_start;
    logic scan_step;   // evaluate entry / advance
    logic scan_rev;    // reverse direction, restart
    logic erase_rd;    // read q[i+1]
    logic erase_step;  // q[i]=q[i+1]
    logic erase_end;   // count--
    logic [2:0] status;
    logic set_status;
  } fdrs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] command;
    logic full;
    logic any_req;
    logic ins_more;    // e < q[pos-1]
    logic ins_pos0;
    logic rem_done;    // all entries of this queue processed
    logic rem_hit;     // removed any in this queue
    logic rem_first;   // working on first-tried queue
    logic scan_done;   // k == cnt
    logic scan_match;
    logic div_busy;
    logic rev_used;
    logic erase_done;
  } fdrs_sts_t;
endpackage

>>> rtl/core/fdrs_ram.sv
// generic single-port-write ram with registered read
module fdrs_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/fdrs_div.sv
// restoring divider, one quotient bit per cycle
module fdrs_div
  import fdrs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SecBits-1:0] dividend,
  input  logic [SptW-1:0]    divisor,
  output logic               busy,
  output logic [TrkW-1:0]    track
);
  localparam int CW = $clog2(SecBits + 1);
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SecBits-1:0] q_r, q_nxt;
  logic [SptW-1:0] rem_r, rem_nxt;
  logic [SptW-1:0] d_r, d_nxt;
  logic [SptW:0] trial;

  assign busy = (cnt_r != '0);
  if (SecBits >= TrkW) begin : g_trk
    assign track = q_r[TrkW-1:0];
  end else begin : g_trk_ext
    assign track = {{(TrkW-SecBits){1'b0}}, q_r};
  end
  assign trial = {rem_r, q_r[SecBits-1]};

  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    d_nxt = d_r;
    if (start) begin
      cnt_nxt = CW'(SecBits);
      q_nxt = dividend;
      rem_nxt = '0;
      d_nxt = (divisor == '0) ? SptW'(1) : divisor;
    end else if (busy) begin
      cnt_nxt = cnt_r - CW'(1);
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = SptW'(trial - {1'b0, d_r});
        q_nxt = {q_r[SecBits-2:0], 1'b1};
      end else begin
        rem_nxt = trial[SptW-1:0];
        q_nxt = {q_r[SecBits-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    d_r <= d_nxt;
  end
endmodule

>>> rtl/core/fdrs_datapath.sv
// queue storage, pointers, track divider and result registers
module fdrs_datapath
  import fdrs_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  fdrs_cmd_t       cmd,
  input  fdrs_in_t        in_data,
  input  logic [SptW-1:0] spt,
  output fdrs_sts_t       sts,
  output fdrs_out_t       res
);
  fdrs_in_t e_r;
  logic [CntW-1:0] cnt1_r, cnt1_nxt, cnt2_r, cnt2_nxt;
  logic use1_r, use1_nxt, out_r, out_nxt;
  logic [TrkW-1:0] head_r, head_nxt;
  logic sel1_r, sel1_nxt;          // queue being worked on
  logic [CntW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic hit_r, hit_nxt, remf_r, remf_nxt, rev_r, rev_nxt;
  logic [19:0] osec_r, osec_nxt;
  logic [7:0] otag_r, otag_nxt;
  logic [2:0] st_r;

  logic we;
  logic [IdxW-1:0] waddr, raddr;
  logic [EntW-1:0] wdata, rd1, rd2, rd;
  logic [TrkW-1:0] trk;
  logic dbusy;
  logic [CntW-1:0] cnt;
  logic [EntW-1:0] ent;
  logic ent_less, ent_eq, tmatch;

  assign ent = {e_r.sector, e_r.tag};
  assign cnt = sel1_r ? cnt1_r : cnt2_r;
  assign rd = sel1_r ? rd1 : rd2;
  assign ent_less = ent < rd;
  assign ent_eq = ent == rd;

  fdrs_ram #(.Width(EntW), .Depth(QDepth)) u_q1 (
    .clk(clk), .we(we & sel1_r), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rd1));
  fdrs_ram #(.Width(EntW), .Depth(QDepth)) u_q2 (
    .clk(clk), .we(we & ~sel1_r), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rd2));

  fdrs_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(rd[EntW-1:8]), .divisor(spt), .busy(dbusy), .track(trk));

  assign tmatch = out_r ? (trk >= head_r) : (trk <= head_r);

  // read address per phase
  always_comb begin
    raddr = '0;
    if (cmd.ins_rd) raddr = IdxW'(i_r - CntW'(1));
    else if (cmd.rem_rd) raddr = i_r[IdxW-1:0];
    else if (cmd.scan_rd)
      raddr = out_r ? k_r[IdxW-1:0] : IdxW'(cnt - CntW'(1) - k_r);
    else if (cmd.erase_rd) raddr = IdxW'(i_r + CntW'(1));
  end

  always_comb begin
    we = 1'b0;
    waddr = i_r[IdxW-1:0];
    wdata = rd;
    if (cmd.ins_shift) begin
      we = 1'b1;
    end else if (cmd.ins_place) begin
      we = 1'b1;
      wdata = ent;
    end else if (cmd.rem_step && !ent_eq) begin
      we = 1'b1;
      waddr = j_r[IdxW-1:0];
    end else if (cmd.erase_step) begin
      we = 1'b1;
    end
  end

  always_comb begin
    cnt1_nxt = cnt1_r; cnt2_nxt = cnt2_r; use1_nxt = use1_r; out_nxt = out_r;
    head_nxt = head_r; sel1_nxt = sel1_r; i_nxt = i_r; j_nxt = j_r; k_nxt = k_r;
    hit_nxt = hit_r; remf_nxt = remf_r; rev_nxt = rev_r;
    osec_nxt = osec_r; otag_nxt = otag_r;
    if (cmd.load) begin
      osec_nxt = '0;
      otag_nxt = '0;
    end
    if (cmd.ins_init) begin
      sel1_nxt = ~use1_r;
      i_nxt = use1_r ? cnt2_r : cnt1_r;
    end
    if (cmd.ins_shift) i_nxt = i_r - CntW'(1);
    if (cmd.ins_place) begin
      if (sel1_r) cnt1_nxt = cnt1_r + CntW'(1);
      else cnt2_nxt = cnt2_r + CntW'(1);
    end
    if (cmd.rem_init) begin
      sel1_nxt = 1'b1; i_nxt = '0; j_nxt = '0; hit_nxt = 1'b0; remf_nxt = 1'b1;
    end
    if (cmd.rem_next_q) begin
      sel1_nxt = 1'b0; i_nxt = '0; j_nxt = '0; hit_nxt = 1'b0; remf_nxt = 1'b0;
    end
    if (cmd.rem_step) begin
      i_nxt = i_r + CntW'(1);
      if (ent_eq) hit_nxt = 1'b1;
      else j_nxt = j_r + CntW'(1);
      if (i_r + CntW'(1) == cnt) begin
        if (sel1_r) cnt1_nxt = ent_eq ? j_r : j_r + CntW'(1);
        else cnt2_nxt = ent_eq ? j_r : j_r + CntW'(1);
      end
    end
    if (cmd.scan_init) begin
      if ((use1_r && cnt1_r == '0) || (!use1_r && cnt2_r == '0)) begin
        use1_nxt = ~use1_r;
        sel1_nxt = ~use1_r;
      end else begin
        sel1_nxt = use1_r;
      end
      k_nxt = '0; rev_nxt = 1'b0;
    end
    if (cmd.scan_step) begin
      if (tmatch) begin
        i_nxt = out_r ? k_r : cnt - CntW'(1) - k_r;
        osec_nxt = 20'(rd[EntW-1:8]);
        otag_nxt = rd[7:0];
        head_nxt = trk;
      end else begin
        k_nxt = k_r + CntW'(1);
      end
    end
    if (cmd.scan_rev) begin
      out_nxt = ~out_r; rev_nxt = 1'b1; k_nxt = '0;
    end
    if (cmd.erase_step) i_nxt = i_r + CntW'(1);
    if (cmd.erase_end) begin
      if (sel1_r) cnt1_nxt = cnt1_r - CntW'(1);
      else cnt2_nxt = cnt2_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt1_r <= '0; cnt2_r <= '0; use1_r <= 1'b1; out_r <= 1'b1; head_r <= '0;
      st_r <= ST_IDLE;
    end else begin
      cnt1_r <= cnt1_nxt; cnt2_r <= cnt2_nxt; use1_r <= use1_nxt;
      out_r <= out_nxt; head_r <= head_nxt;
      if (cmd.set_status) st_r <= cmd.status;
    end
    if (cmd.load) e_r <= in_data;
    sel1_r <= sel1_nxt; i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt;
    hit_r <= hit_nxt; remf_r <= remf_nxt; rev_r <= rev_nxt;
    osec_r <= osec_nxt; otag_r <= otag_nxt;
  end

  assign sts.command = e_r.command;
  assign sts.full = (use1_r ? cnt2_r : cnt1_r) == CntW'(QDepth);
  assign sts.any_req = (cnt1_r != '0) || (cnt2_r != '0);
  assign sts.ins_more = ent_less;
  assign sts.ins_pos0 = (i_r == '0);
  // count shrinks to the kept entries on the last step
  assign sts.rem_done = (i_r >= cnt);
  assign sts.rem_hit = hit_r;
  assign sts.rem_first = remf_r;
  assign sts.scan_done = (k_r == cnt);
  assign sts.scan_match = tmatch;
  assign sts.div_busy = dbusy;
  assign sts.rev_used = rev_r;
  assign sts.erase_done = (i_r + CntW'(1) >= cnt);

  assign res.status = st_r;
  assign res.out_sector = osec_r;
  assign res.out_tag = otag_r;
  assign res.out_track = head_r;
  assign res.moving_outward = out_r;
  assign res.serving_first_queue = use1_r;
endmodule

>>> rtl/core/fdrs_ctrl.sv
// sequencer for add, remove and dispatch transactions
module fdrs_ctrl
  import fdrs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  fdrs_sts_t sts,
  output fdrs_cmd_t cmd
);
  `include "flook_disk_request_scheduler_macros.svh"

  fdrs_state_t state_r, state_nxt;
  logic erase_r, erase_nxt;   // scan phase vs erase phase

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);

  always_comb begin
    state_nxt = state_r;
    erase_nxt = erase_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        case (sts.command)
          CMD_ADD: state_nxt = sts.full ? S_DONE : S_INS_RD;
          CMD_REM: state_nxt = S_REM_RD;
          CMD_NEXT: begin
            erase_nxt = 1'b0;
            state_nxt = sts.any_req ? S_SCAN_RD : S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_INS_RD: state_nxt = sts.ins_pos0 ? S_DONE : S_INS_WAIT;
      S_INS_WAIT: state_nxt = S_INS_CHK;
      S_INS_CHK: state_nxt = sts.ins_more ? S_INS_RD : S_DONE;
      S_REM_RD: begin
        if (sts.rem_done) begin
          if (sts.rem_hit) state_nxt = S_DONE;
          else if (sts.rem_first) state_nxt = S_REM_RD;
          else state_nxt = S_DONE;
        end else begin
          state_nxt = S_REM_WAIT;
        end
      end
      S_REM_WAIT: state_nxt = S_REM_STEP;
      S_REM_STEP: state_nxt = S_REM_RD;
      S_SCAN_RD: begin
        if (erase_r) state_nxt = sts.erase_done ? S_DONE : S_SCAN_WAIT;
        else if (sts.scan_done) state_nxt = sts.rev_used ? S_DONE : S_SCAN_RD;
        else state_nxt = S_SCAN_WAIT;
      end
      S_SCAN_WAIT: state_nxt = erase_r ? S_SCAN_CHK : S_DIV;
      S_DIV: state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (erase_r) state_nxt = S_SCAN_RD;
        else if (sts.div_busy) state_nxt = S_SCAN_CHK;
        else begin
          if (sts.scan_match) erase_nxt = 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_DONE: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: cmd.load = in_valid;
      S_DECODE: begin
        cmd.set_status = 1'b1;
        case (sts.command)
          CMD_ADD: begin
            cmd.status = sts.full ? ST_FULL : ST_OK;
            cmd.ins_init = !sts.full;
          end
          CMD_REM: begin
            cmd.status = ST_OK;
            cmd.rem_init = 1'b1;
          end
          CMD_NEXT: begin
            cmd.status = ST_IDLE;
            cmd.scan_init = sts.any_req;
          end
          default: cmd.status = ST_IDLE;
        endcase
      end
      S_INS_RD: begin
        cmd.ins_rd = 1'b1;
        cmd.ins_place = sts.ins_pos0;
      end
      S_INS_WAIT: cmd.ins_rd = 1'b1;
      S_INS_CHK: begin
        cmd.ins_rd = 1'b1;
        cmd.ins_shift = sts.ins_more;
        cmd.ins_place = !sts.ins_more;
      end
      S_REM_RD: begin
        cmd.rem_rd = 1'b1;
        if (sts.rem_done && !sts.rem_hit) begin
          if (sts.rem_first) cmd.rem_next_q = 1'b1;
          else begin
            cmd.set_status = 1'b1;
            cmd.status = ST_NOTFOUND;
          end
        end
      end
      S_REM_WAIT: cmd.rem_rd = 1'b1;
      S_REM_STEP: begin
        cmd.rem_rd = 1'b1;
        cmd.rem_step = 1'b1;
      end
      S_SCAN_RD: begin
        cmd.scan_rd = !erase_r;
        cmd.erase_rd = erase_r;
        if (erase_r && sts.erase_done) begin
          cmd.erase_end = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status = ST_DISP;
        end else if (!erase_r && sts.scan_done) cmd.scan_rev = 1'b1;
      end
      S_SCAN_WAIT: begin
        cmd.scan_rd = !erase_r;
        cmd.erase_rd = erase_r;
      end
      S_DIV: begin
        cmd.scan_rd = 1'b1;
        cmd.div_start = 1'b1;
      end
      S_SCAN_CHK: begin
        cmd.scan_rd = !erase_r;
        cmd.erase_rd = erase_r;
        cmd.erase_step = erase_r;
        cmd.scan_step = !erase_r && !sts.div_busy;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      erase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      erase_r <= erase_nxt;
    end
  end

  `FDRS_ASSERT_IMP(a_rdy_idle, in_ready, !out_valid)
  `FDRS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `FDRS_ASSERT_NXT(a_accept_busy, in_valid && in_ready, !in_ready)
  `FDRS_ASSERT_IMP(a_one_write, 1'b1, $countones({cmd.ins_shift, cmd.ins_place, cmd.erase_step}) <= 1)
endmodule

>>> rtl/core/flook_disk_request_scheduler.sv
// F-LOOK disk request scheduler: two sorted request queues in ram
// add: sorted insert shifting from the tail; remove: first queue, then second if none matched
// dispatch: up to two scans using the 20-step divider per entry, then erase
// one transaction in flight at a time; result held until taken
// synchronous active-low reset: queues empty, first queue active, outward, head 0
// queue contents are undefined after reset; only entries below the counts are read
module flook_disk_request_scheduler
  import fdrs_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  fdrs_in_t        in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output fdrs_out_t       out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [SptW-1:0] cfg_data
);
  fdrs_cmd_t cmd;
  fdrs_sts_t sts;
  logic [SptW-1:0] spt_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r <= SptW'(63);
    end else if (cfg_valid) begin
      spt_r <= cfg_data;
    end
  end

  fdrs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd));

  fdrs_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_data(in_data), .spt(spt_r),
    .sts(sts), .res(out_data));
endmodule

>>> tb/tb_flook_disk_request_scheduler.sv
// self-checking testbench for the f-look disk request scheduler
`timescale 1ns / 1ps
module tb_flook_disk_request_scheduler;
  import fdrs_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  fdrs_in_t in_data;
  fdrs_out_t out_data;
  logic [SptW-1:0] cfg_data;

  flook_disk_request_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  typedef struct packed {
    logic [SecBits-1:0] sector;
    logic [7:0] tag;
  } req_t;

  // predictor state
  req_t q_first[$];
  req_t q_second[$];
  logic serve_first;
  logic outward;
  logic [TrkW-1:0] head;
  logic [SptW-1:0] spt;

  fdrs_out_t pending[$];
  int mismatches;
  int results_seen;
  int sent;
  bit stall_mode;

  function automatic logic [TrkW-1:0] track_of(logic [SecBits-1:0] s);
    logic [SptW-1:0] d;
    d = (spt == 0) ? SptW'(1) : spt;
    return TrkW'(s / d);
  endfunction

  function automatic bit req_less(req_t a, req_t b);
    return (a.sector < b.sector) || (a.sector == b.sector && a.tag < b.tag);
  endfunction

  function automatic bit sorted_insert(ref req_t q[$], input req_t e);
    int pos;
    if (q.size() >= QDepth) return 1'b0;
    pos = q.size();
    while (pos > 0 && req_less(e, q[pos-1])) pos--;
    q.insert(pos, e);
    return 1'b1;
  endfunction

  function automatic int drop_matches(ref req_t q[$], input req_t e);
    int n;
    n = 0;
    for (int i = q.size() - 1; i >= 0; i--)
      if (q[i] == e) begin
        q.delete(i);
        n++;
      end
    return n;
  endfunction

  function automatic int find_nearest(ref req_t q[$]);
    int i;
    logic [TrkW-1:0] t;
    for (int k = 0; k < q.size(); k++) begin
      i = outward ? k : q.size() - 1 - k;
      t = track_of(q[i].sector);
      if (outward ? (t >= head) : (t <= head)) return i;
    end
    return -1;
  endfunction

  function automatic fdrs_out_t schedule(fdrs_in_t it);
    fdrs_out_t r;
    req_t e;
    int idx;
    e.sector = it.sector;
    e.tag = it.tag;
    r = '0;
    r.status = ST_IDLE;
    case (it.command)
      CMD_ADD: begin
        if (serve_first) r.status = sorted_insert(q_second, e) ? ST_OK : ST_FULL;
        else r.status = sorted_insert(q_first, e) ? ST_OK : ST_FULL;
      end
      CMD_REM: begin
        if (drop_matches(q_first, e) > 0) r.status = ST_OK;
        else if (drop_matches(q_second, e) > 0) r.status = ST_OK;
        else r.status = ST_NOTFOUND;
      end
      CMD_NEXT: begin
        if (q_first.size() != 0 || q_second.size() != 0) begin
          if ((serve_first && q_first.size() == 0) || (!serve_first && q_second.size() == 0))
            serve_first = !serve_first;
          idx = -1;
          for (int p = 0; p < 2 && idx < 0; p++) begin
            idx = serve_first ? find_nearest(q_first) : find_nearest(q_second);
            if (idx < 0) outward = !outward;
          end
          if (idx >= 0) begin
            e = serve_first ? q_first[idx] : q_second[idx];
            if (serve_first) q_first.delete(idx);
            else q_second.delete(idx);
            r.out_sector = e.sector;
            r.out_tag = e.tag;
            head = track_of(e.sector);
            r.status = ST_DISP;
          end
        end
      end
      default: ;
    endcase
    r.out_track = head;
    r.moving_outward = outward;
    r.serving_first_queue = serve_first;
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // valid stays high after the handshake until the next falling edge decides
  task automatic send_item(logic [1:0] cmd, logic [SecBits-1:0] sec, logic [7:0] tg);
    fdrs_in_t it;
    fdrs_out_t exp_item;
    int g;
    g = stall_mode ? gap_len() : 0;
    @(negedge clk);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    it.command = cmd;
    it.sector = sec;
    it.tag = tg;
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp_item = schedule(it);
    pending = {pending, exp_item};
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_spt(logic [SptW-1:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    spt = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        fdrs_out_t exp_r;
        exp_r = pending.pop_front();
        if (out_data !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_r, out_data);
        end
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (!stall_mode) out_ready <= 1'b1;
    else if ($urandom_range(0, 19) == 0) out_ready <= 1'b0;
    else if ($urandom_range(0, 2) == 0) out_ready <= 1'b1;
  end

  task automatic test_directed();
    stall_mode = 0;
    send_item(CMD_NEXT, 0, 0);                 // idle with both queues empty
    send_item(CMD_REM, 5, 1);                  // not found
    send_item(CMD_NOP, 20'hFFFFF, 8'hFF);      // unused command
    send_item(CMD_ADD, 20'hFFFFF, 8'hFF);
    send_item(CMD_ADD, 0, 0);
    send_item(CMD_ADD, 100, 7);
    send_item(CMD_ADD, 100, 3);                // equal sectors order by tag
    send_item(CMD_ADD, 100, 3);                // duplicate
    send_item(CMD_REM, 100, 3);                // removes both duplicates
    send_item(CMD_NEXT, 0, 0);                 // switches queue
    send_item(CMD_NEXT, 0, 0);
    send_item(CMD_NEXT, 0, 0);
    send_item(CMD_ADD, 10, 1);
    send_item(CMD_NEXT, 0, 0);                 // reversal
    send_item(CMD_NEXT, 0, 0);
    for (int i = 0; i < QDepth + 1; i++) send_item(CMD_ADD, 20'(i * 97), 8'(i)); // full
    for (int i = 0; i < 4; i++) send_item(CMD_NEXT, 0, 0);
    write_spt(0);                              // zero divisor
    send_item(CMD_NEXT, 0, 0);
    send_item(CMD_NEXT, 0, 0);
  endtask

  task automatic test_random(int n, logic [SptW-1:0] s);
    logic [SecBits-1:0] sec;
    logic [7:0] tg;
    req_t pool[$];
    req_t nr;
    int r;
    write_spt(s);
    stall_mode = 1;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) sec = SecBits'($urandom());
      else sec = SecBits'($urandom_range(0, 4000));
      tg = 8'($urandom_range(0, 255));
      if (r < 45) begin
        if (pool.size() > 0 && $urandom_range(0, 5) == 0) begin
          sec = pool[$urandom_range(0, pool.size()-1)].sector;
        end
        nr.sector = sec;
        nr.tag = tg;
        pool = {pool, nr};
        send_item(CMD_ADD, sec, tg);
      end else if (r < 60) begin
        if (pool.size() > 0 && $urandom_range(0, 3) != 0) begin
          sec = pool[$urandom_range(0, pool.size()-1)].sector;
          tg = pool[$urandom_range(0, pool.size()-1)].tag;
        end
        send_item(CMD_REM, sec, tg);
      end else if (r < 97) begin
        send_item(CMD_NEXT, sec, tg);
      end else begin
        send_item(CMD_NOP, sec, tg);
      end
      if (pool.size() > 60) pool.delete(0);
      if (i == n / 2) drain();                 // sender waits for all results
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    mismatches = 0;
    results_seen = 0;
    sent = 0;
    stall_mode = 0;
    q_first.delete();
    q_second.delete();
    serve_first = 1'b1;
    outward = 1'b1;
    head = '0;
    spt = 13'd63;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(150, 13'd63);
    test_random(130, 13'd1);
    test_random(130, 13'd4096);
    test_random(100, 13'h1FFF);
    drain();
    $display("covered %0d transactions, %0d results, divisors 0, 1, 63, 4096, 8191",
             sent, results_seen);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("tb_flook_disk_request_scheduler: done, clean");
    end else begin
      $display("tb_flook_disk_request_scheduler: done, errors");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("timeout");
    $display("tb_flook_disk_request_scheduler: done, errors");
    $finish;
  end
endmodule
